// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk_s, rst_s, expr) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (expr)) \
        else $error("assertion failed");

// when ante holds, cons must hold in the next cycle
`define ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk_s, rst_s, expr)
`define ASSERT_NEXT(label, clk_s, rst_s, ante, cons)

`endif

`endif

// ===== design/mpp_pkg.sv =====
// ----------------------------------------------------------------------------
// mpp_pkg
// Types, codes, the property kind decoder and a varint group helper for the MQTT 5 property parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mpp_pkg;

    typedef enum logic [2:0] {
        EV_DONE  = 3'd0,
        EV_VALUE = 3'd1,
        EV_DATA  = 3'd2,
        EV_EMPTY = 3'd3,
        EV_ERROR = 3'd4
    } event_t;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_LEN_VB  = 3'd1;
    localparam logic [2:0] ERR_SHORT   = 3'd2;
    localparam logic [2:0] ERR_UNKNOWN = 3'd3;
    localparam logic [2:0] ERR_OVERRUN = 3'd4;
    localparam logic [2:0] ERR_SUB_VB  = 3'd5;

    localparam logic [7:0] ID_USER = 8'h26;

    typedef enum logic [3:0] {
        K_NONE = 4'd0,
        K_INT1 = 4'd1,
        K_INT2 = 4'd2,
        K_INT4 = 4'd4,
        K_VAR  = 4'd5,
        K_DATA = 4'd6,
        K_PAIR = 4'd8
    } kind_t;

    typedef struct packed {
        event_t      event_res;
        logic [7:0]  prop_id;
        logic [31:0] value;
        logic [7:0]  data_byte;
        logic        data_last;
        logic        pair_part;
        logic        section_done;
        logic [28:0] section_bytes;
        logic [2:0]  error_code;
    } res_t;

    // property id -> payload encoding
    function automatic kind_t kind_of(input logic [7:0] id);
        kind_t k;
        unique case (id) inside
            8'd1, 8'd23, 8'd25, 8'd36, 8'd37, 8'd40, 8'd41, 8'd42: k = K_INT1;
            8'd19, 8'd33, 8'd34, 8'd35:                            k = K_INT2;
            8'd2, 8'd17, 8'd24, 8'd39:                             k = K_INT4;
            8'd11:                                                 k = K_VAR;
            8'd3, 8'd8, 8'd9, 8'd18, 8'd21, 8'd22, 8'd26, 8'd28, 8'd31:
                k = K_DATA;
            8'd38:                                                 k = K_PAIR;
            default:                                               k = K_NONE;
        endcase
        return k;
    endfunction

    // 7-bit varint group placed at its position
    function automatic logic [27:0] vb_group(input logic [1:0] cnt, input logic [7:0] b);
        logic [27:0] g;
        case (cnt)
            2'd0:    g = {21'd0, b[6:0]};
            2'd1:    g = {14'd0, b[6:0], 7'd0};
            2'd2:    g = {7'd0, b[6:0], 14'd0};
            default: g = {b[6:0], 21'd0};
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

// ===== design/mqtt5_property_parser_core.sv =====
// ----------------------------------------------------------------------------
// mqtt5_property_parser_core
// Byte-serial parser for an MQTT 5 property section.
// ----------------------------------------------------------------------------
// An accepted byte's result is in the output register in the next cycle.
// Throughput: one byte per cycle unless a held result stalls input; the whole
// per-byte state update is one level of logic between the parse and output registers.
// s_axis_tready = !m_axis_tvalid || m_axis_tready.
// Reset (rst_n low, async) returns to reading the section length, output empty.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mqtt5_property_parser_core
    import mpp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire logic        s_axis_tlast,   // buffer_last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [87:0]      m_axis_tdata,   // [7:0] prop_id, [39:8] value,
                                             // [47:40] data_byte, [48] section_done,
                                             // [77:49] section_bytes,
                                             // [80:78] error_code, rest zero
    output logic [3:0]       m_axis_tuser,   // [2:0] event_res, [3] pair_part
    output logic             m_axis_tlast    // data_last
);

    typedef enum logic [2:0] {
        PH_LEN, PH_ID, PH_INT, PH_SUBVAR, PH_LENHI, PH_LENLO, PH_DATA
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [27:0] varint_accum_reg, varint_accum_next;
    logic [1:0]  varint_count_reg, varint_count_next;
    logic [27:0] section_left_reg, section_left_next;
    logic [28:0] section_total_reg, section_total_next;
    logic [7:0]  current_id_reg, current_id_next;
    logic [15:0] field_left_reg, field_left_next;
    logic [31:0] value_accum_reg, value_accum_next;
    logic        pair_second_reg, pair_second_next;

    logic        out_valid_reg, out_valid_next;
    res_t        res_reg, res_next;

    logic        in_fire;
    logic [7:0]  b;
    logic        last;

    // per-byte decode
    logic        emit;
    logic        raise;
    logic [7:0]  err_id;
    logic [2:0]  err_code;
    logic        fin_field;
    logic        fin_string;
    logic [27:0] acc;
    logic [27:0] left_dec;
    logic [15:0] fl;
    kind_t       kind;
    res_t        ev;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign b             = s_axis_tdata;
    assign last          = s_axis_tlast;

    assign acc      = varint_accum_reg | vb_group(varint_count_reg, b);
    assign left_dec = section_left_reg - 28'd1;
    assign kind     = kind_of(b);

    always_comb
    begin
        phase_next         = phase_reg;
        varint_accum_next  = varint_accum_reg;
        varint_count_next  = varint_count_reg;
        section_left_next  = section_left_reg;
        section_total_next = section_total_reg;
        current_id_next    = current_id_reg;
        field_left_next    = field_left_reg;
        value_accum_next   = value_accum_reg;
        pair_second_next   = pair_second_reg;

        emit       = 1'b0;
        raise      = 1'b0;
        err_id     = 8'd0;
        err_code   = ERR_NONE;
        fin_field  = 1'b0;
        fin_string = 1'b0;
        fl         = field_left_reg;
        ev         = '0;
        ev.event_res = EV_DONE;

        if (phase_reg == PH_LEN)
        begin
            if (b[7])
            begin
                if (varint_count_reg == 2'd3)
                begin
                    raise    = 1'b1;
                    err_code = ERR_LEN_VB;
                end
                else if (last)
                begin
                    raise    = 1'b1;
                    err_code = ERR_SHORT;
                end
                else
                begin
                    varint_accum_next = acc;
                    varint_count_next = varint_count_reg + 2'd1;
                end
            end
            else
            begin
                section_total_next = {1'b0, acc} + {27'd0, varint_count_reg} + 29'd1;
                section_left_next  = acc;
                varint_accum_next  = '0;
                varint_count_next  = '0;
                if (acc == 28'd0)
                begin
                    emit      = 1'b1;
                    fin_field = 1'b1;
                end
                else if (last)
                begin
                    raise    = 1'b1;
                    err_code = ERR_SHORT;
                end
                else
                begin
                    phase_next = PH_ID;
                end
            end
        end
        else
        begin
            section_left_next = left_dec;
            if (last && left_dec != 28'd0)
            begin
                raise    = 1'b1;
                err_id   = current_id_reg;
                err_code = ERR_SHORT;
            end
            else
            begin
                unique case (phase_reg)
                    PH_ID:
                    begin
                        current_id_next   = b;
                        pair_second_next  = 1'b0;
                        value_accum_next  = '0;
                        varint_accum_next = '0;
                        varint_count_next = '0;
                        err_id            = b;
                        case (kind) inside
                            K_NONE:
                            begin
                                raise    = 1'b1;
                                err_code = ERR_UNKNOWN;
                            end
                            K_VAR:
                            begin
                                if (left_dec == 28'd0)
                                begin
                                    raise    = 1'b1;
                                    err_code = ERR_SUB_VB;
                                end
                                else
                                begin
                                    phase_next = PH_SUBVAR;
                                end
                            end
                            K_DATA, K_PAIR:
                            begin
                                if (left_dec < 28'd2)
                                begin
                                    raise    = 1'b1;
                                    err_code = ERR_OVERRUN;
                                end
                                else
                                begin
                                    phase_next = PH_LENHI;
                                end
                            end
                            default:
                            begin
                                if (left_dec < {24'd0, kind})
                                begin
                                    raise    = 1'b1;
                                    err_code = ERR_OVERRUN;
                                end
                                else
                                begin
                                    field_left_next = {12'd0, kind};
                                    phase_next      = PH_INT;
                                end
                            end
                        endcase
                    end
                    PH_INT:
                    begin
                        value_accum_next = {value_accum_reg[23:0], b};
                        fl               = field_left_reg - 16'd1;
                        field_left_next  = fl;
                        if (fl == 16'd0)
                        begin
                            emit         = 1'b1;
                            ev.event_res = EV_VALUE;
                            ev.prop_id   = current_id_reg;
                            ev.value     = {value_accum_reg[23:0], b};
                            fin_field    = 1'b1;
                        end
                    end
                    PH_SUBVAR:
                    begin
                        if (b[7])
                        begin
                            if (varint_count_reg == 2'd3 || left_dec == 28'd0)
                            begin
                                raise    = 1'b1;
                                err_id   = current_id_reg;
                                err_code = ERR_SUB_VB;
                            end
                            else
                            begin
                                varint_accum_next = acc;
                                varint_count_next = varint_count_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            emit         = 1'b1;
                            ev.event_res = EV_VALUE;
                            ev.prop_id   = current_id_reg;
                            ev.value     = {4'd0, acc};
                            fin_field    = 1'b1;
                        end
                    end
                    PH_LENHI:
                    begin
                        field_left_next = {b, 8'd0};
                        phase_next      = PH_LENLO;
                    end
                    PH_LENLO:
                    begin
                        fl              = field_left_reg | {8'd0, b};
                        field_left_next = fl;
                        if ({12'd0, fl} > left_dec)
                        begin
                            raise    = 1'b1;
                            err_id   = current_id_reg;
                            err_code = ERR_OVERRUN;
                        end
                        else if (fl == 16'd0)
                        begin
                            emit         = 1'b1;
                            ev.event_res = EV_EMPTY;
                            ev.prop_id   = current_id_reg;
                            ev.pair_part = pair_second_reg;
                            fin_string   = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        fl              = field_left_reg - 16'd1;
                        field_left_next = fl;
                        emit            = 1'b1;
                        ev.event_res    = EV_DATA;
                        ev.prop_id      = current_id_reg;
                        ev.data_byte    = b;
                        ev.pair_part    = pair_second_reg;
                        if (fl == 16'd0)
                        begin
                            ev.data_last = 1'b1;
                            fin_string   = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_LEN;
                    end
                endcase
            end
        end

        // string done: a user property key is followed by its value string
        if (fin_string)
        begin
            if (current_id_reg == ID_USER && !pair_second_reg)
            begin
                if (left_dec < 28'd2)
                begin
                    raise    = 1'b1;
                    err_id   = current_id_reg;
                    err_code = ERR_OVERRUN;
                end
                else
                begin
                    pair_second_next = 1'b1;
                    phase_next       = PH_LENHI;
                end
            end
            else
            begin
                pair_second_next = 1'b0;
                fin_field        = 1'b1;
            end
        end

        if (fin_field && !raise)
        begin
            if (section_left_next == 28'd0)
            begin
                ev.section_done  = 1'b1;
                ev.section_bytes = section_total_next;
                phase_next         = PH_LEN;
                varint_accum_next  = '0;
                varint_count_next  = '0;
                section_left_next  = '0;
                section_total_next = '0;
                current_id_next    = '0;
                field_left_next    = '0;
                value_accum_next   = '0;
                pair_second_next   = 1'b0;
            end
            else
            begin
                phase_next        = PH_ID;
                value_accum_next  = '0;
                varint_accum_next = '0;
                varint_count_next = '0;
                field_left_next   = '0;
            end
        end

        // an error replaces any event of this byte and clears all state
        if (raise)
        begin
            emit          = 1'b1;
            ev            = '0;
            ev.event_res  = EV_ERROR;
            ev.prop_id    = err_id;
            ev.error_code = err_code;
            phase_next         = PH_LEN;
            varint_accum_next  = '0;
            varint_count_next  = '0;
            section_left_next  = '0;
            section_total_next = '0;
            current_id_next    = '0;
            field_left_next    = '0;
            value_accum_next   = '0;
            pair_second_next   = 1'b0;
        end

        res_next       = ev;
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (in_fire)
        begin
            out_valid_next = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_LEN;
            varint_accum_reg  <= '0;
            varint_count_reg  <= '0;
            section_left_reg  <= '0;
            section_total_reg <= '0;
            current_id_reg    <= '0;
            field_left_reg    <= '0;
            value_accum_reg   <= '0;
            pair_second_reg   <= 1'b0;
            out_valid_reg     <= 1'b0;
            res_reg           <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                phase_reg         <= phase_next;
                varint_accum_reg  <= varint_accum_next;
                varint_count_reg  <= varint_count_next;
                section_left_reg  <= section_left_next;
                section_total_reg <= section_total_next;
                current_id_reg    <= current_id_next;
                field_left_reg    <= field_left_next;
                value_accum_reg   <= value_accum_next;
                pair_second_reg   <= pair_second_next;
            end
            // payload register, loaded with each request that yields a result
            if (in_fire && emit)
            begin
                res_reg <= res_next;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, res_reg.error_code, res_reg.section_bytes,
                            res_reg.section_done, res_reg.data_byte, res_reg.value,
                            res_reg.prop_id};
    assign m_axis_tuser  = {res_reg.pair_part, res_reg.event_res};
    assign m_axis_tlast  = res_reg.data_last;

    // an error always returns the parser to the length phase
    `ASSERT_NEXT(a_error_clears, clk, rst_n, in_fire && raise,
                 phase_reg == PH_LEN && varint_count_reg == 2'd0 && section_left_reg == 28'd0)
    // a finished section leaves nothing outstanding
    `ASSERT_NEXT(a_done_clears, clk, rst_n, in_fire && emit && res_next.section_done,
                 phase_reg == PH_LEN && field_left_reg == 16'd0 && !pair_second_reg)
    // last-byte mark only on data bytes, never with an error
    `ASSERT_ALWAYS(a_last_on_data, clk, rst_n,
                   !(out_valid_reg && res_reg.data_last) || res_reg.event_res == EV_DATA)
    `ASSERT_ALWAYS(a_err_not_done, clk, rst_n,
                   !(out_valid_reg && res_reg.event_res == EV_ERROR) || !res_reg.section_done)

endmodule

`default_nettype wire

// ===== sim/tb_mqtt5_property_parser_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mqtt5_property_parser_core
// Streams MQTT 5 property sections into the parser byte by byte: a short
// directed set, then mostly well-formed sections with random content, mixed
// with damaged sections and noise. A byte-level parse model in the bench
// predicts every event, and each output beat is checked field by field in
// order. The sender and receiver idle at varying rates, and one long receiver
// hold-off backs the parser up.
// ----------------------------------------------------------------------------

module tb_mqtt5_property_parser_core;
    import mpp_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_BYTES = 350;

    typedef enum logic [2:0] {
        PS_LEN,
        PS_ID,
        PS_INT,
        PS_SUBID,
        PS_LEN_HI,
        PS_LEN_LO,
        PS_DATA
    } parse_state_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } wire_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic        s_axis_tlast = 1'b0;    // buffer_last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;           // prop_id, value, data_byte, section_done,
                                         // section_bytes, error_code, zero pad
    logic [3:0]  m_axis_tuser;           // event_res, pair_part
    logic        m_axis_tlast;           // data_last

    mqtt5_property_parser_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 clk = ~clk;

    // stimulus and expected events
    wire_byte_t   wire_bytes_q[$];
    res_t         parser_events_q[$];
    logic [7:0]   body[$];
    wire_byte_t   drive_item;
    logic         in_taken = 1'b0;
    int           gen_count = 0;
    int           send_idle_pct = 0;
    int           stall_pct = 0;
    int           hold_asks = 0;
    int           holds_done = 0;
    int           hold_left = 0;
    int           quiet_cycles = 0;
    int           fail_count = 0;
    int           bytes_in = 0;
    int           ev_tally[5];
    int           err_tally[6];
    int           sections_closed = 0;

    // parse model state
    kind_t        kind_map [0:255];
    parse_state_t pst;
    logic [27:0]  vb_acc;
    logic [1:0]   vb_cnt;
    logic [27:0]  sec_left;
    logic [28:0]  sec_total;
    logic [7:0]   cur_id;
    logic [15:0]  fld_left;
    logic [31:0]  num_acc;
    logic         in_value;
    res_t         next_res;
    bit           next_emit;

    task automatic clear_parse();
        pst = PS_LEN;
        vb_acc = '0;
        vb_cnt = '0;
        sec_left = '0;
        sec_total = '0;
        cur_id = '0;
        fld_left = '0;
        num_acc = '0;
        in_value = 1'b0;
    endtask

    task automatic raise_err(input logic [7:0] id, input logic [2:0] code);
        next_res = '0;
        next_res.event_res = EV_ERROR;
        next_res.prop_id = id;
        next_res.error_code = code;
        next_emit = 1'b1;
        clear_parse();
    endtask

    task automatic finish_field();
        if (sec_left == 0) begin
            next_res.section_done = 1'b1;
            next_res.section_bytes = sec_total;
            clear_parse();
        end
        else begin
            pst = PS_ID;
            num_acc = '0;
            vb_acc = '0;
            vb_cnt = '0;
            fld_left = '0;
        end
    endtask

    // a user property key is followed by its value string
    task automatic finish_string();
        if (cur_id == ID_USER && !in_value) begin
            if (sec_left < 2)
                raise_err(cur_id, ERR_OVERRUN);
            else begin
                in_value = 1'b1;
                pst = PS_LEN_HI;
            end
        end
        else begin
            in_value = 1'b0;
            finish_field();
        end
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic last);
        kind_t k;
        next_res = '0;
        next_emit = 1'b0;
        if (pst == PS_LEN) begin
            vb_acc = vb_acc | ({21'd0, b[6:0]} << (7 * vb_cnt));
            if (b[7]) begin
                if (vb_cnt == 2'd3)
                    raise_err(8'h00, ERR_LEN_VB);
                else if (last)
                    raise_err(8'h00, ERR_SHORT);
                else
                    vb_cnt = vb_cnt + 2'd1;
            end
            else begin
                sec_left = vb_acc;
                sec_total = {27'd0, vb_cnt} + 29'd1 + {1'b0, vb_acc};
                vb_acc = '0;
                vb_cnt = '0;
                if (sec_left == 0) begin
                    next_res.event_res = EV_DONE;
                    next_emit = 1'b1;
                    finish_field();
                end
                else if (last)
                    raise_err(8'h00, ERR_SHORT);
                else
                    pst = PS_ID;
            end
        end
        else begin
            sec_left = sec_left - 28'd1;
            // a short buffer wins over every other check on the byte
            if (last && sec_left != 0)
                raise_err(cur_id, ERR_SHORT);
            else begin
                case (pst)
                    PS_ID: begin
                        cur_id = b;
                        in_value = 1'b0;
                        num_acc = '0;
                        vb_acc = '0;
                        vb_cnt = '0;
                        k = kind_map[b];
                        if (k == K_NONE)
                            raise_err(b, ERR_UNKNOWN);
                        else if (k == K_VAR) begin
                            if (sec_left == 0)
                                raise_err(b, ERR_SUB_VB);
                            else
                                pst = PS_SUBID;
                        end
                        else if (k == K_DATA || k == K_PAIR) begin
                            if (sec_left < 2)
                                raise_err(b, ERR_OVERRUN);
                            else
                                pst = PS_LEN_HI;
                        end
                        else if (sec_left < {24'd0, k})
                            raise_err(b, ERR_OVERRUN);
                        else begin
                            fld_left = {12'd0, k};
                            pst = PS_INT;
                        end
                    end
                    PS_INT: begin
                        num_acc = {num_acc[23:0], b};
                        fld_left = fld_left - 16'd1;
                        if (fld_left == 0) begin
                            next_res.event_res = EV_VALUE;
                            next_res.prop_id = cur_id;
                            next_res.value = num_acc;
                            next_emit = 1'b1;
                            finish_field();
                        end
                    end
                    PS_SUBID: begin
                        vb_acc = vb_acc | ({21'd0, b[6:0]} << (7 * vb_cnt));
                        if (b[7]) begin
                            if (vb_cnt == 2'd3 || sec_left == 0)
                                raise_err(cur_id, ERR_SUB_VB);
                            else
                                vb_cnt = vb_cnt + 2'd1;
                        end
                        else begin
                            next_res.event_res = EV_VALUE;
                            next_res.prop_id = cur_id;
                            next_res.value = {4'd0, vb_acc};
                            next_emit = 1'b1;
                            finish_field();
                        end
                    end
                    PS_LEN_HI: begin
                        fld_left = {b, 8'h00};
                        pst = PS_LEN_LO;
                    end
                    PS_LEN_LO: begin
                        fld_left = {fld_left[15:8], b};
                        if ({12'd0, fld_left} > sec_left)
                            raise_err(cur_id, ERR_OVERRUN);
                        else if (fld_left == 0) begin
                            next_res.event_res = EV_EMPTY;
                            next_res.prop_id = cur_id;
                            next_res.pair_part = in_value;
                            next_emit = 1'b1;
                            finish_string();
                        end
                        else
                            pst = PS_DATA;
                    end
                    default: begin
                        fld_left = fld_left - 16'd1;
                        next_res.event_res = EV_DATA;
                        next_res.prop_id = cur_id;
                        next_res.data_byte = b;
                        next_res.pair_part = in_value;
                        next_emit = 1'b1;
                        if (fld_left == 0) begin
                            next_res.data_last = 1'b1;
                            finish_string();
                        end
                    end
                endcase
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        fail_count++;
        $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    endtask

    task automatic cmp_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    task automatic check_result();
        res_t want;
        if (parser_events_q.size() == 0)
            report_mismatch("result with no request outstanding", 64'd1, 64'd0);
        else begin
            want = parser_events_q.pop_front();
            cmp_field("event_res", 64'(m_axis_tuser[2:0]), 64'(want.event_res));
            cmp_field("prop_id", 64'(m_axis_tdata[7:0]), 64'(want.prop_id));
            cmp_field("value", 64'(m_axis_tdata[39:8]), 64'(want.value));
            cmp_field("data_byte", 64'(m_axis_tdata[47:40]), 64'(want.data_byte));
            cmp_field("data_last", 64'(m_axis_tlast), 64'(want.data_last));
            cmp_field("pair_part", 64'(m_axis_tuser[3]), 64'(want.pair_part));
            cmp_field("section_done", 64'(m_axis_tdata[48]), 64'(want.section_done));
            cmp_field("section_bytes", 64'(m_axis_tdata[77:49]), 64'(want.section_bytes));
            cmp_field("error_code", 64'(m_axis_tdata[80:78]), 64'(want.error_code));
            cmp_field("tdata pad", 64'(m_axis_tdata[87:81]), 64'd0);
            ev_tally[want.event_res]++;
            if (want.event_res == EV_ERROR)
                err_tally[want.error_code]++;
            if (want.section_done)
                sections_closed++;
        end
    endtask

    // input monitor, output checker and watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                bytes_in++;
                parse_byte(s_axis_tdata, s_axis_tlast);
                if (next_emit)
                    parser_events_q.insert(parser_events_q.size(), next_res);
            end
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[%0t] no handshake for %0d cycles", $realtime, QUIET_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // sender: hold the request until it is taken
    always @(negedge clk) begin
        if (rst_n && (!s_axis_tvalid || in_taken)) begin
            if (wire_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                drive_item = wire_bytes_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= drive_item.data;
                s_axis_tlast <= drive_item.last;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver, with a long hold-off on request
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_asks != holds_done) begin
                holds_done = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic last);
        wire_byte_t w;
        w.data = b;
        w.last = last;
        wire_bytes_q.insert(wire_bytes_q.size(), w);
        gen_count++;
    endtask

    task automatic body_add(input logic [7:0] v);
        body.insert(body.size(), v);
    endtask

    function automatic logic [7:0] edge_byte();
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic add_string();
        int len;
        int r;
        r = $urandom_range(99);
        if (r < 60)
            len = $urandom_range(4);
        else if (r < 95)
            len = $urandom_range(5, 20);
        else
            len = $urandom_range(130, 300);
        body_add(8'(len >> 8));
        body_add(8'(len));
        repeat (len) body_add(8'($urandom_range(255)));
    endtask

    task automatic add_prop();
        logic [7:0] id;
        logic [6:0] grp;
        kind_t      k;
        int         n;
        id = 8'($urandom_range(42));
        while (kind_map[id] == K_NONE)
            id = 8'($urandom_range(42));
        k = kind_map[id];
        body_add(id);
        case (k)
            K_VAR: begin
                // five groups overflow the subscription id
                n = ($urandom_range(19) == 0) ? 5 : $urandom_range(1, 4);
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(3))
                        0:       grp = 7'h00;
                        1:       grp = 7'h7F;
                        default: grp = 7'($urandom_range(127));
                    endcase
                    body_add({i < n - 1, grp});
                end
            end
            K_DATA:
                add_string();
            K_PAIR: begin
                add_string();
                add_string();
            end
            default:
                repeat (int'(k)) body_add(edge_byte());
        endcase
    endtask

    // one section; a damaged one is followed by a byte that ends the buffer
    task automatic send_section(input bit broken);
        logic [27:0] len;
        logic [27:0] shifted;
        logic [7:0]  b;
        int          mode;
        int          n;
        int          min_groups;
        int          total;
        int          cut;
        body.delete();
        if ($urandom_range(9) != 0)
            repeat ($urandom_range(1, 4)) add_prop();
        len = 28'(body.size());
        mode = broken ? $urandom_range(4) : -1;
        case (mode)
            0: len = len + 28'($urandom_range(1, 3));
            1: if (len != 0) len = len - 28'd1 - 28'($urandom_range((len > 3) ? 2 : len - 1));
            2: if (body.size() != 0) body[$urandom_range(body.size() - 1)] = edge_byte();
            4: len = 28'($urandom);
            default: ;
        endcase
        min_groups = (len < 128) ? 1 : (len < 16384) ? 2 : (len < 2097152) ? 3 : 4;
        n = ($urandom_range(3) == 0) ? $urandom_range(min_groups, 4) : min_groups;
        total = n + body.size();
        cut = (mode == 3) ? $urandom_range(total - 1) : total - 1;
        for (int i = 0; i <= cut; i++) begin
            if (i < n) begin
                shifted = len >> (7 * i);
                b = {i < n - 1, shifted[6:0]};
            end
            else
                b = body[i - n];
            if (i != cut)
                push_byte(b, 1'b0);
            else
                push_byte(b, (mode == 3) ? 1'b1 : 1'($urandom_range(1)));
        end
        if (broken)
            push_byte(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 8))
            push_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
        push_byte(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic fill_random(input int goal);
        int r;
        while (gen_count < goal) begin
            r = $urandom_range(99);
            if (r < 75)
                send_section(1'b0);
            else if (r < 95)
                send_section(1'b1);
            else
                send_noise();
        end
    endtask

    task automatic wait_drained();
        while (wire_bytes_q.size() != 0 || s_axis_tvalid || parser_events_q.size() != 0)
            @(posedge clk);
    endtask

    initial begin
        for (int i = 0; i < 256; i++)
            kind_map[i] = K_NONE;
        for (int i = 0; i < 5; i++)
            ev_tally[i] = 0;
        for (int i = 0; i < 6; i++)
            err_tally[i] = 0;
        kind_map[1] = K_INT1;   kind_map[23] = K_INT1;  kind_map[25] = K_INT1;
        kind_map[36] = K_INT1;  kind_map[37] = K_INT1;  kind_map[40] = K_INT1;
        kind_map[41] = K_INT1;  kind_map[42] = K_INT1;
        kind_map[19] = K_INT2;  kind_map[33] = K_INT2;  kind_map[34] = K_INT2;
        kind_map[35] = K_INT2;
        kind_map[2] = K_INT4;   kind_map[17] = K_INT4;  kind_map[24] = K_INT4;
        kind_map[39] = K_INT4;
        kind_map[11] = K_VAR;
        kind_map[3] = K_DATA;   kind_map[8] = K_DATA;   kind_map[9] = K_DATA;
        kind_map[18] = K_DATA;  kind_map[21] = K_DATA;  kind_map[22] = K_DATA;
        kind_map[26] = K_DATA;  kind_map[28] = K_DATA;  kind_map[31] = K_DATA;
        kind_map[38] = K_PAIR;
        clear_parse();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty section, then one with a padded 4-byte length
        push_byte(8'h00, 1'b1);
        push_byte(8'h80, 1'b0); push_byte(8'h80, 1'b0);
        push_byte(8'h80, 1'b0); push_byte(8'h00, 1'b0);
        // length varint still continuing on its 4th byte
        push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
        // subscription id continues past the section end
        push_byte(8'h03, 1'b0); push_byte(8'h0B, 1'b0);
        push_byte(8'h80, 1'b0); push_byte(8'h80, 1'b0);
        // user property with empty key and value, buffer ends with it
        push_byte(8'h05, 1'b0); push_byte(ID_USER, 1'b0); push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b1);
        // empty key leaves no room for the value length
        push_byte(8'h04, 1'b0); push_byte(ID_USER, 1'b0);
        push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
        // unknown id, then a buffer that ends inside a section
        push_byte(8'h02, 1'b0); push_byte(8'hFF, 1'b0);
        push_byte(8'h02, 1'b0); push_byte(8'h01, 1'b1);
        wait_drained();

        send_idle_pct = 0;  stall_pct = 0;
        fill_random(gen_count + PHASE_BYTES);
        wait_drained();
        send_idle_pct = 63; stall_pct = 0;
        fill_random(gen_count + PHASE_BYTES);
        wait_drained();
        send_idle_pct = 0;  stall_pct = 63;
        fill_random(gen_count + PHASE_BYTES);
        wait_drained();
        send_idle_pct = 26; stall_pct = 26;
        fill_random(gen_count + PHASE_BYTES);
        wait_drained();

        // receiver backs off while the sender keeps pushing
        send_idle_pct = 0;  stall_pct = 0;
        hold_asks++;
        fill_random(gen_count + PHASE_BYTES);
        wait_drained();

        repeat (8) @(posedge clk);
        $display("run: %0d bytes, %0d values, %0d data bytes, %0d empty, %0d sections",
                 bytes_in, ev_tally[EV_VALUE], ev_tally[EV_DATA], ev_tally[EV_EMPTY],
                 sections_closed);
        $display("errors: length %0d, short %0d, unknown id %0d, overrun %0d, sub id %0d",
                 err_tally[ERR_LEN_VB], err_tally[ERR_SHORT], err_tally[ERR_UNKNOWN],
                 err_tally[ERR_OVERRUN], err_tally[ERR_SUB_VB]);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
